// ===== rtl/m4m_pkg.sv =====
// Package with the constants, types and state codes of the matrix multiplier.
`default_nettype none
package m4m_pkg;

    localparam int DIM       = 4;
    localparam int FRAC_BITS = 16;
    localparam int CELLS     = DIM * DIM;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + $clog2(DIM);
    localparam int RC_W      = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int IDX_W     = $clog2(CELLS);
    localparam int OUT_IDX_W = 4;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RUN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [RC_W-1:0]   row;
        logic [RC_W-1:0]   col;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } t_load;

    typedef struct packed {
        logic                    valid;
        logic                    last;
        logic [IDX_W-1:0]        idx;
        logic [RC_W-1:0]         row;
        logic [RC_W-1:0]         col;
        logic signed [ACC_W-1:0] sum;
    } t_token;

endpackage
`default_nettype wire

// ===== rtl/m4m_if.sv =====
// Handshake interfaces for the element input channel and the product output channel.
`default_nettype none
interface m4m_in_if;
    logic                         valid;
    logic                         ready;
    logic signed [m4m_pkg::DATA_W-1:0] a_element;
    logic signed [m4m_pkg::DATA_W-1:0] b_element;

    modport source (output valid, output a_element, output b_element, input ready);
    modport sink   (input valid, input a_element, input b_element, output ready);
endinterface

interface m4m_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [m4m_pkg::DATA_W-1:0]    product_element;
    logic [m4m_pkg::OUT_IDX_W-1:0]        element_index;
    logic                            last_of_run;

    modport source (output valid, output product_element, output element_index,
                    output last_of_run, input ready);
    modport sink   (input valid, input product_element, input element_index,
                    input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/m4m_cell.sv =====
// One multiply-accumulate cell of the chain, holding one column of A and one row of B.
`default_nettype none
module m4m_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic [m4m_pkg::RC_W-1:0]  i_cell_idx,
    input  wire m4m_pkg::t_load            i_load,
    input  wire m4m_pkg::t_token           i_tok,
    output m4m_pkg::t_token                o_tok,
    output logic                           o_busy
);
    import m4m_pkg::*;

    logic [DATA_W-1:0]        r_a_col [DIM];
    logic [DATA_W-1:0]        r_b_row [DIM];
    t_token                   r_mid;
    t_token                   r_tok;
    t_token                   n_tok;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DATA_W-1:0] w_a;
    logic signed [DATA_W-1:0] w_b;

    always_ff @(posedge i_clk) begin
        if (i_load.valid && i_load.col == i_cell_idx) begin
            r_a_col[i_load.row] <= i_load.a;
        end
        if (i_load.valid && i_load.row == i_cell_idx) begin
            r_b_row[i_load.col] <= i_load.b;
        end
    end

    assign w_a = $signed(r_a_col[i_tok.row]);
    assign w_b = $signed(r_b_row[i_tok.col]);

    always_comb begin
        n_tok     = r_mid;
        n_tok.sum = r_mid.sum + ACC_W'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid.valid <= 1'b0;
            r_tok.valid <= 1'b0;
        end else if (i_en) begin
            r_mid  <= i_tok;
            r_prod <= w_a * w_b;
            r_tok  <= n_tok;
        end
    end

    assign o_tok  = r_tok;
    assign o_busy = r_mid.valid || r_tok.valid;

endmodule
`default_nettype wire

// ===== rtl/matrix4_multiply.sv =====
// Top level of the 4x4 fixed-point matrix multiplier built from a chain of MAC cells.
// Sixteen input transactions load A and B, one per cycle; the block then takes no input.
// Products pass both registers of each cell, then the output register; one per cycle unless stalled.
// A full run loads sixteen elements, issues sixteen tokens into the two-stage cells of the chain, then drains.
// Output stalls freeze the whole chain. Reset clears control state; stores start undefined.
`default_nettype none
module matrix4_multiply (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    m4m_in_if.sink     i_in,
    m4m_out_if.source  o_out
);
    import m4m_pkg::*;

    t_state           r_state, n_state;
    logic [RC_W-1:0]  r_lrow, n_lrow, r_lcol, n_lcol;
    logic [RC_W-1:0]  r_irow, n_irow, r_icol, n_icol;
    logic [IDX_W-1:0] r_iidx, n_iidx;
    logic             w_en;
    logic             w_load_last;
    logic             w_issue_last;
    t_load            w_load;
    t_token           w_chain [DIM+1];
    logic [DIM-1:0]   w_busy;

    logic signed [ACC_W-1:0]  w_shift;
    logic [ACC_W-DATA_W:0]    w_upper;
    logic signed [DATA_W-1:0] w_sat;

    logic                     r_o_valid;
    logic signed [DATA_W-1:0] r_o_data;
    logic [OUT_IDX_W-1:0]     r_o_idx;
    logic                     r_o_last;

    assign w_en         = !r_o_valid || o_out.ready;
    assign i_in.ready   = (r_state == ST_LOAD);
    assign w_load_last  = (r_lrow == RC_W'(DIM - 1)) && (r_lcol == RC_W'(DIM - 1));
    assign w_issue_last = (r_irow == RC_W'(DIM - 1)) && (r_icol == RC_W'(DIM - 1));

    assign w_load.valid = i_in.valid && i_in.ready;
    assign w_load.row   = r_lrow;
    assign w_load.col   = r_lcol;
    assign w_load.a     = i_in.a_element;
    assign w_load.b     = i_in.b_element;

    assign w_chain[0].valid = (r_state == ST_RUN);
    assign w_chain[0].last  = w_issue_last;
    assign w_chain[0].idx   = r_iidx;
    assign w_chain[0].row   = r_irow;
    assign w_chain[0].col   = r_icol;
    assign w_chain[0].sum   = '0;

    for (genvar g = 0; g < DIM; g++) begin : g_cell
        m4m_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (w_en),
            .i_cell_idx (RC_W'(g)),
            .i_load     (w_load),
            .i_tok      (w_chain[g]),
            .o_tok      (w_chain[g+1]),
            .o_busy     (w_busy[g])
        );
    end

    always_comb begin
        n_state = r_state;
        n_lrow  = r_lrow;
        n_lcol  = r_lcol;
        n_irow  = r_irow;
        n_icol  = r_icol;
        n_iidx  = r_iidx;
        unique case (r_state)
            ST_LOAD: begin
                if (w_load.valid) begin
                    if (r_lcol == RC_W'(DIM - 1)) begin
                        n_lcol = '0;
                        n_lrow = r_lrow + 1'b1;
                    end else begin
                        n_lcol = r_lcol + 1'b1;
                    end
                    if (w_load_last) begin
                        n_lrow  = '0;
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (w_en) begin
                    n_iidx = r_iidx + 1'b1;
                    if (r_icol == RC_W'(DIM - 1)) begin
                        n_icol = '0;
                        n_irow = r_irow + 1'b1;
                    end else begin
                        n_icol = r_icol + 1'b1;
                    end
                    if (w_issue_last) begin
                        n_irow  = '0;
                        n_iidx  = '0;
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_busy == '0) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_lrow  <= '0;
            r_lcol  <= '0;
            r_irow  <= '0;
            r_icol  <= '0;
            r_iidx  <= '0;
        end else begin
            r_state <= n_state;
            r_lrow  <= n_lrow;
            r_lcol  <= n_lcol;
            r_irow  <= n_irow;
            r_icol  <= n_icol;
            r_iidx  <= n_iidx;
        end
    end

    assign w_shift = $signed(w_chain[DIM].sum) >>> FRAC_BITS;
    assign w_upper = w_shift[ACC_W-1:DATA_W-1];

    always_comb begin
        if ((&w_upper) || !(|w_upper)) begin
            w_sat = w_shift[DATA_W-1:0];
        end else if (w_shift[ACC_W-1]) begin
            w_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= w_chain[DIM].valid;
            r_o_data  <= w_sat;
            r_o_idx   <= OUT_IDX_W'(w_chain[DIM].idx);
            r_o_last  <= w_chain[DIM].last;
        end
    end

    assign o_out.valid           = r_o_valid;
    assign o_out.product_element = r_o_data;
    assign o_out.element_index   = r_o_idx;
    assign o_out.last_of_run     = r_o_last;

endmodule
`default_nettype wire

// ===== tb/sv/matrix4_multiply_test.sv =====
// Self-checking testbench for the 4x4 fixed-point matrix multiplier: directed table, random runs.
module matrix4_multiply_test;
    timeunit 1ns;
    timeprecision 1ps;

    import m4m_pkg::DIM;
    import m4m_pkg::FRAC_BITS;
    import m4m_pkg::CELLS;
    import m4m_pkg::DATA_W;
    import m4m_pkg::OUT_IDX_W;

    localparam int SUM_W        = 2 * DATA_W + 2;
    localparam int RANDOM_RUNS  = 22;
    localparam int PAUSE_RUN    = 9;
    localparam int HOLD_CYCLES  = 200;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 2 * DIM + 12;

    localparam logic [DATA_W-1:0] Q_MAX   = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN   = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q_ZERO  = 32'h0000_0000;
    localparam logic [DATA_W-1:0] Q_ONE   = 32'h0001_0000;
    localparam logic [DATA_W-1:0] Q_M_ONE = 32'hFFFF_0000;
    localparam logic [DATA_W-1:0] Q_ULP   = 32'h0000_0001;
    localparam logic [DATA_W-1:0] Q_M_ULP = 32'hFFFF_FFFF;

    localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W - DATA_W){1'b0}}, Q_MAX};
    localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W - DATA_W){1'b1}}, Q_MIN};

    typedef enum int {
        FILL_FULL,
        FILL_SMALL,
        FILL_CORNER,
        FILL_MIXED
    } t_fill_style;

    typedef struct packed {
        logic [DATA_W-1:0]    value;
        logic [OUT_IDX_W-1:0] index;
        logic                 last;
    } t_product;

    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic              known;
        logic [DATA_W-1:0] product;
    } t_directed_row;

    // Row r of A and column c of B meet at product index r*4+c; each row of the table
    // carries A and B at that index and, where obvious, the product there.
    localparam t_directed_row DIRECTED_ROWS [CELLS] = '{
        '{Q_MAX,   Q_MAX,  1'b1, Q_MAX},
        '{Q_MAX,   Q_MIN,  1'b1, Q_MIN},
        '{Q_MAX,   Q_ZERO, 1'b1, Q_ZERO},
        '{Q_MAX,   Q_ZERO, 1'b1, 32'h0000_7FFF},
        '{Q_MIN,   Q_MAX,  1'b1, Q_MIN},
        '{Q_MIN,   Q_MIN,  1'b1, Q_MAX},
        '{Q_MIN,   Q_ZERO, 1'b1, Q_ZERO},
        '{Q_MIN,   Q_ULP,  1'b1, 32'hFFFF_8000},
        '{Q_ZERO,  Q_MAX,  1'b1, Q_ZERO},
        '{Q_ZERO,  Q_MIN,  1'b1, Q_ZERO},
        '{Q_ZERO,  Q_ZERO, 1'b1, Q_ZERO},
        '{Q_ZERO,  Q_ZERO, 1'b1, Q_ZERO},
        '{Q_ONE,   Q_MAX,  1'b0, Q_ZERO},
        '{Q_M_ULP, Q_MIN,  1'b0, Q_ZERO},
        '{Q_ZERO,  Q_ZERO, 1'b1, Q_ZERO},
        '{Q_ZERO,  Q_ZERO, 1'b1, Q_M_ULP}
    };

    logic i_clk;
    logic i_rst_n;

    m4m_in_if  in_bus ();
    m4m_out_if out_bus ();

    matrix4_multiply u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    logic signed [DATA_W-1:0] a_grid [CELLS];
    logic signed [DATA_W-1:0] b_grid [CELLS];
    int                       cells_loaded = 0;
    logic [DATA_W-1:0]        typed_product [CELLS];
    bit                       typed_known [CELLS];
    t_product                 pending_products [$];
    int                       products_seen = 0;
    int                       error_count = 0;
    int                       idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [DATA_W-1:0] random_element(t_fill_style style);
        case (style)
            FILL_FULL: begin
                return $urandom;
            end
            FILL_SMALL: begin
                return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            end
            default: begin
                case ($urandom_range(0, 5))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return Q_ZERO;
                    3: return Q_ONE;
                    4: return Q_M_ONE;
                    default: return Q_M_ULP;
                endcase
            end
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] compute_product_element(int row, int col);
        logic signed [SUM_W-1:0] total;
        logic signed [SUM_W-1:0] scaled;
        total = '0;
        for (int k = 0; k < DIM; k++) begin
            total = total + a_grid[row * DIM + k] * b_grid[k * DIM + col];
        end
        scaled = total >>> FRAC_BITS;
        if (scaled > SAT_HI) return Q_MAX;
        if (scaled < SAT_LO) return Q_MIN;
        return scaled[DATA_W-1:0];
    endfunction

    function automatic void load_element(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
        t_product rec;
        a_grid[cells_loaded] = a;
        b_grid[cells_loaded] = b;
        cells_loaded++;
        if (cells_loaded == CELLS) begin
            cells_loaded = 0;
            for (int idx = 0; idx < CELLS; idx++) begin
                rec.value = typed_known[idx] ? typed_product[idx]
                                             : compute_product_element(idx / DIM, idx % DIM);
                rec.index = OUT_IDX_W'(idx);
                rec.last  = (idx == CELLS - 1);
                pending_products.push_back(rec);
            end
            foreach (typed_known[i]) typed_known[i] = 1'b0;
        end
    endfunction

    task automatic idle_input(int cycles);
        if (cycles > 0) begin
            in_bus.valid <= 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    task automatic offer_element(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
        in_bus.valid     <= 1'b1;
        in_bus.a_element <= a;
        in_bus.b_element <= b;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        load_element(a, b);
        @(negedge i_clk);
    endtask

    task automatic report_mismatch(string field, int index, logic [DATA_W-1:0] want,
                                   logic [DATA_W-1:0] got);
        $display("%0t: %s mismatch at position %0d, expected %h, got %h",
                 $time, field, index, want, got);
        error_count++;
    endtask

    task automatic check_product();
        t_product want;
        if (pending_products.size() == 0) begin
            $display("%0t: unexpected product transaction, expected none, got %h index %0d",
                     $time, out_bus.product_element, out_bus.element_index);
            error_count++;
        end else begin
            want = pending_products.pop_front();
            if (out_bus.product_element !== want.value)
                report_mismatch("product_element", int'(want.index), want.value,
                                out_bus.product_element);
            if (out_bus.element_index !== want.index)
                report_mismatch("element_index", int'(want.index), DATA_W'(want.index),
                                DATA_W'(out_bus.element_index));
            if (out_bus.last_of_run !== want.last)
                report_mismatch("last_of_run", int'(want.index), DATA_W'(want.last),
                                DATA_W'(out_bus.last_of_run));
        end
    endtask

    initial begin : product_sink
        int  stall;
        bit  hold_done;
        hold_done     = 1'b0;
        out_bus.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = gap_length();
            if (!hold_done && products_seen >= 3 * CELLS) begin
                hold_done = 1'b1;
                stall     = HOLD_CYCLES;
            end else if (products_seen >= 10 * CELLS && products_seen < 15 * CELLS) begin
                stall = 0;
            end
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_bus.ready <= 1'b1;
            do @(posedge i_clk); while (out_bus.valid !== 1'b1);
            check_product();
            products_seen++;
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
            (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d product elements outstanding",
                     $time, IDLE_LIMIT, pending_products.size());
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : element_source
        t_fill_style run_style;
        t_fill_style style;
        in_bus.valid     = 1'b0;
        in_bus.a_element = '0;
        in_bus.b_element = '0;
        i_rst_n          = 1'b0;
        foreach (typed_known[i]) begin
            typed_known[i]   = DIRECTED_ROWS[i].known;
            typed_product[i] = DIRECTED_ROWS[i].product;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < CELLS; i++) begin
            idle_input(gap_length());
            offer_element(DIRECTED_ROWS[i].a, DIRECTED_ROWS[i].b);
        end

        for (int run = 0; run < RANDOM_RUNS; run++) begin
            if (run == PAUSE_RUN && pending_products.size() != 0) begin
                in_bus.valid <= 1'b0;
                while (pending_products.size() != 0) @(negedge i_clk);
            end
            run_style = t_fill_style'($urandom_range(0, 3));
            for (int e = 0; e < CELLS; e++) begin
                style = (run_style == FILL_MIXED) ? t_fill_style'($urandom_range(0, 2))
                                                  : run_style;
                if (run < 2 || run >= 6) idle_input(gap_length());
                offer_element(random_element(style), random_element(style));
            end
        end
        in_bus.valid <= 1'b0;

        while (pending_products.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
